>>> hw/rtl/dstwr_pkg.sv
// Shared types and constants for the two-way ranging responder.
`default_nettype none

package dstwr_pkg;

   localparam int ID_W        = 8;
   localparam int TYPE_W      = 8;
   localparam int LEN_W       = 10;
   localparam int TIME_W      = 40;
   localparam int STAMP_W     = 32;
   localparam int SCALE_W     = 24;
   localparam int DIST_W      = 16;
   localparam int OUTCOME_W   = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 40;
   localparam int MUL_W       = 32;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int DEN_W       = STAMP_W + 2;
   localparam int DIV_STEPS   = PROD_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int TOF_LIMIT_W = 40;

   localparam logic [LEN_W-1:0]   MAX_FRAME_BYTES = LEN_W'(24);
   localparam logic [TYPE_W-1:0]  TYPE_POLL       = 8'hF1;
   localparam logic [TYPE_W-1:0]  TYPE_FINAL      = 8'hF3;
   localparam logic [SCALE_W-1:0] SCALE_RESET     = SCALE_W'(307385);
   localparam logic [DIST_W-1:0]  DIST_MAX        = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_MY_ID          = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESPONSE_DELAY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_SCALE = 2'd2;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_FAIL     = 2'd0,
      OUT_RESPOND  = 2'd1,
      OUT_DISTANCE = 2'd2
   } outcome_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_P1,
      ST_MUL_P2,
      ST_SUB,
      ST_DIV,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                operation;
      logic [ID_W-1:0]     peer_id;
      logic [TYPE_W-1:0]   frame_type;
      logic [ID_W-1:0]     frame_source;
      logic [ID_W-1:0]     frame_dest;
      logic [LEN_W-1:0]    frame_length;
      logic [TIME_W-1:0]   rx_time;
      logic [TIME_W-1:0]   tx_time;
      logic [STAMP_W-1:0]  round_a;
      logic [STAMP_W-1:0]  reply_a;
   } req_item_type;

   typedef struct packed {
      outcome_type         outcome;
      logic [STAMP_W-1:0]  response_time;
      logic [ID_W-1:0]     response_target;
      logic [DIST_W-1:0]   distance;
   } rsp_item_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/dstwr_if.sv
// Handshake channel interfaces for requests, responses and register writes.
`default_nettype none

interface dstwr_req_if;
   import dstwr_pkg::*;
   logic                valid;
   logic                ready;
   logic                operation;
   logic [ID_W-1:0]     peer_id;
   logic [TYPE_W-1:0]   frame_type;
   logic [ID_W-1:0]     frame_source;
   logic [ID_W-1:0]     frame_dest;
   logic [LEN_W-1:0]    frame_length;
   logic [TIME_W-1:0]   rx_time;
   logic [TIME_W-1:0]   tx_time;
   logic [STAMP_W-1:0]  round_a;
   logic [STAMP_W-1:0]  reply_a;
   modport source (output valid, operation, peer_id, frame_type, frame_source, frame_dest,
                   frame_length, rx_time, tx_time, round_a, reply_a, input ready);
   modport sink (input valid, operation, peer_id, frame_type, frame_source, frame_dest,
                 frame_length, rx_time, tx_time, round_a, reply_a, output ready);
endinterface

interface dstwr_rsp_if;
   import dstwr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic [STAMP_W-1:0]   response_time;
   logic [ID_W-1:0]      response_target;
   logic [DIST_W-1:0]    distance;
   modport source (output valid, outcome, response_time, response_target, distance,
                   input ready);
   modport sink (input valid, outcome, response_time, response_target, distance,
                 output ready);
endinterface

interface dstwr_csr_if;
   import dstwr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dstwr_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
`default_nettype none

module dstwr_mul (
   input  wire logic                          clock,
   input  wire logic [dstwr_pkg::MUL_W-1:0]   mul_a,
   input  wire logic [dstwr_pkg::MUL_W-1:0]   mul_b,
   output logic      [dstwr_pkg::PROD_W-1:0]  product_ff
);
   import dstwr_pkg::*;

   logic [PROD_W-1:0] product_in;

   assign product_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/dstwr_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none

module dstwr_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [dstwr_pkg::PROD_W-1:0]  dividend,
   input  wire logic [dstwr_pkg::DEN_W-1:0]   divisor,
   output dstwr_pkg::div_status_type          status,
   output logic      [dstwr_pkg::PROD_W-1:0]  quotient
);
   import dstwr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [DEN_W:0]       shifted;
   logic [DEN_W:0]       trial;
   logic                 fits;

   // The quotient register starts out holding the dividend; its top bit is
   // shifted into the partial remainder each step as a quotient bit comes in below.
   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[PROD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   always_comb begin
      status.busy = busy_ff;
      status.done = done_ff;
   end

   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ds_twr_responder.sv
// Top level of the two-way ranging responder: sequencer, registers and checks.
//
// Channel   Direction  Word
// req_bus   in         one receive event (frame header, timestamps, initiator times)
// rsp_bus   out        outcome, delayed response time and target, distance
// csr_bus   in         register index and write data, always ready
//
// A failed or poll event gives its response word after the check step, and a matching
// final frame with a zero divisor or no positive flight time after the subtract step.
// A matching final frame that divides runs through the 64-step serial divider and the
// passes through the shared 32x32 multiplier; the passes after the divide are skipped
// when the quotient saturates.
// The block takes one event at a time; the next event is accepted once the
// sequencer is back in idle, even while the previous response word waits.
// Synchronous reset returns to waiting for a poll with default registers.
`default_nettype none

module ds_twr_responder (
   input  wire logic  clock,
   input  wire logic  reset,
   dstwr_req_if.sink  req_bus,
   dstwr_rsp_if.source rsp_bus,
   dstwr_csr_if.sink  csr_bus
);
   import dstwr_pkg::*;

   state_type          state_ff, state_in;
   logic               awaiting_ff, awaiting_in;
   logic [ID_W-1:0]    target_ff, target_in;
   logic [TIME_W-1:0]  poll_time_ff, poll_time_in;
   logic [ID_W-1:0]    my_id_ff;
   logic [TIME_W-1:0]  delay_ff;
   logic [SCALE_W-1:0] scale_ff;
   req_item_type       item_ff, item_in;
   logic [STAMP_W-1:0] rb_ff, rb_in;
   logic [STAMP_W-1:0] db_ff, db_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [PROD_W-1:0]  p1_ff, p1_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   rsp_item_type       res_ff, res_in;
   rsp_item_type       rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic               div_start;
   div_status_type     div_stat;
   logic [PROD_W-1:0]  div_quo;
   logic [PROD_W:0]    diff;
   logic [PROD_W-1:0]  total;
   logic [TIME_W-1:0]  resp_sum;
   logic [TIME_W-1:0]  rb_full, db_full;
   logic               bad_frame;
   logic               poll_ok, final_ok;

   dstwr_mul u_mul (
      .clock      (clock),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .product_ff (mul_p)
   );

   dstwr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff[PROD_W-1:0]),
      .divisor  (den_ff),
      .status   (div_stat),
      .quotient (div_quo)
   );

   assign bad_frame = item_ff.operation || (item_ff.frame_length > MAX_FRAME_BYTES);
   assign poll_ok   = (item_ff.frame_type == TYPE_POLL) &&
                      (item_ff.frame_source == item_ff.peer_id) &&
                      (item_ff.frame_dest == my_id_ff);
   assign final_ok  = (item_ff.frame_type == TYPE_FINAL) &&
                      (item_ff.frame_source == target_ff) &&
                      (item_ff.frame_dest == my_id_ff);
   assign resp_sum  = item_ff.rx_time + delay_ff;
   assign rb_full   = item_ff.rx_time - item_ff.tx_time;
   assign db_full   = item_ff.tx_time - poll_time_ff;
   assign diff      = {1'b0, p1_ff} - {1'b0, mul_p};
   assign total     = acc_ff + {mul_p[MUL_W-1:0], {MUL_W{1'b0}}};

   always_comb begin
      state_in     = state_ff;
      awaiting_in  = awaiting_ff;
      target_in    = target_ff;
      poll_time_in = poll_time_ff;
      item_in      = item_ff;
      rb_in        = rb_ff;
      db_in        = db_ff;
      den_in       = den_ff;
      p1_in        = p1_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               item_in.operation    = req_bus.operation;
               item_in.peer_id      = req_bus.peer_id;
               item_in.frame_type   = req_bus.frame_type;
               item_in.frame_source = req_bus.frame_source;
               item_in.frame_dest   = req_bus.frame_dest;
               item_in.frame_length = req_bus.frame_length;
               item_in.rx_time      = req_bus.rx_time;
               item_in.tx_time      = req_bus.tx_time;
               item_in.round_a      = req_bus.round_a;
               item_in.reply_a      = req_bus.reply_a;
               state_in             = ST_CHECK;
            end
         end
         ST_CHECK: begin
            res_in.outcome         = OUT_FAIL;
            res_in.response_time   = '0;
            res_in.response_target = '0;
            res_in.distance        = '0;
            state_in               = ST_DONE;
            if (bad_frame) begin
               awaiting_in = 1'b0;
            end else if (!awaiting_ff) begin
               if (poll_ok) begin
                  awaiting_in            = 1'b1;
                  target_in              = item_ff.frame_source;
                  poll_time_in           = item_ff.rx_time;
                  res_in.outcome         = OUT_RESPOND;
                  res_in.response_time   = resp_sum[TIME_W-1:TIME_W-STAMP_W];
                  res_in.response_target = item_ff.frame_source;
               end
            end else begin
               awaiting_in = 1'b0;
               if (final_ok) begin
                  rb_in    = rb_full[STAMP_W-1:0];
                  db_in    = db_full[STAMP_W-1:0];
                  den_in   = DEN_W'(item_ff.round_a) + DEN_W'(rb_full[STAMP_W-1:0]) +
                             DEN_W'(item_ff.reply_a) + DEN_W'(db_full[STAMP_W-1:0]);
                  state_in = ST_MUL_P1;
               end
            end
         end
         ST_MUL_P1: begin
            mul_a    = item_ff.round_a;
            mul_b    = rb_ff;
            state_in = ST_MUL_P2;
         end
         ST_MUL_P2: begin
            mul_a    = item_ff.reply_a;
            mul_b    = db_ff;
            p1_in    = mul_p;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            // mul_p now holds the second product; the borrow of diff is the compare.
            state_in = ST_DONE;
            if (den_ff == '0) begin
               res_in.outcome = OUT_FAIL;
            end else if (!diff[PROD_W] && (diff[PROD_W-1:0] != '0)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               res_in.outcome  = OUT_DISTANCE;
               res_in.distance = '0;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            res_in.outcome = OUT_DISTANCE;
            if (|div_quo[PROD_W-1:TOF_LIMIT_W]) begin
               res_in.distance = DIST_MAX;
               state_in        = ST_DONE;
            end else begin
               mul_a    = div_quo[MUL_W-1:0];
               mul_b    = MUL_W'(scale_ff);
               state_in = ST_MUL_HI;
            end
         end
         ST_MUL_HI: begin
            mul_a    = MUL_W'(div_quo[TOF_LIMIT_W-1:MUL_W]);
            mul_b    = MUL_W'(scale_ff);
            acc_in   = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // Scaled flight time is Q16; keep bits 31:16 unless the upper half is set.
            if (|total[PROD_W-1:MUL_W]) begin
               res_in.distance = DIST_MAX;
            end else begin
               res_in.distance = total[MUL_W-1:MUL_W-DIST_W];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b0;
         target_ff    <= '0;
         poll_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
         my_id_ff     <= '0;
         delay_ff     <= '0;
         scale_ff     <= SCALE_RESET;
      end else begin
         awaiting_ff  <= awaiting_in;
         target_ff    <= target_in;
         poll_time_ff <= poll_time_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               CSR_MY_ID:          my_id_ff <= csr_bus.data[ID_W-1:0];
               CSR_RESPONSE_DELAY: delay_ff <= csr_bus.data[TIME_W-1:0];
               CSR_DISTANCE_SCALE: scale_ff <= csr_bus.data[SCALE_W-1:0];
               default: begin
               end
            endcase
         end
      end
      item_ff <= item_in;
      rb_ff   <= rb_in;
      db_ff   <= db_in;
      den_ff  <= den_in;
      p1_ff   <= p1_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign csr_bus.ready           = 1'b1;
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.outcome         = rsp_ff.outcome;
   assign rsp_bus.response_time   = rsp_ff.response_time;
   assign rsp_bus.response_target = rsp_ff.response_target;
   assign rsp_bus.distance        = rsp_ff.distance;

   // The divider only runs while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == ST_DIV)
      else $error("divider busy outside the divide step");

   // Entering the final-frame phase always comes with a response request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(awaiting_ff) |-> (state_ff == ST_DONE) && (res_ff.outcome == OUT_RESPOND))
      else $error("final-frame phase entered without a response request");

   // Only a response request carries a transmit time and a target.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.outcome != OUT_RESPOND) |->
         (rsp_ff.response_time == '0) && (rsp_ff.response_target == '0))
      else $error("response fields set on a word that is not a response request");

endmodule

`default_nettype wire

>>> test/ds_twr_responder_tb.sv
// Self-checking testbench for the two-way ranging responder with a predicting scoreboard.
`timescale 1ns / 1ps

module ds_twr_responder_tb;
   import dstwr_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 200;
   localparam int HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES = 80;

   // Tracks the responder's ranging state and the response words it owes.
   class ranging_tracker;
      logic [ID_W-1:0]    node_id;
      logic [TIME_W-1:0]  reply_delay;
      logic [SCALE_W-1:0] scale;
      bit                 awaiting_final;
      logic [ID_W-1:0]    peer;
      logic [TIME_W-1:0]  poll_stamp;
      rsp_item_type       owed_words[$];
      int                 failures;

      function new();
         node_id = '0;
         reply_delay = '0;
         scale = SCALE_RESET;
         awaiting_final = 1'b0;
         peer = '0;
         poll_stamp = '0;
         failures = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_MY_ID:          node_id = data[ID_W-1:0];
            CSR_RESPONSE_DELAY: reply_delay = data[TIME_W-1:0];
            CSR_DISTANCE_SCALE: scale = data[SCALE_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return owed_words.size();
      endfunction

      function void note_event(req_item_type ev);
         rsp_item_type      want;
         logic [TIME_W-1:0] due;
         logic [31:0]       rb;
         logic [31:0]       db;
         logic [63:0]       p1;
         logic [63:0]       p2;
         logic [63:0]       flight;
         logic [63:0]       scaled;
         logic [33:0]       den;
         want = '0;
         want.outcome = OUT_FAIL;
         if (ev.operation || ev.frame_length > MAX_FRAME_BYTES) begin
            awaiting_final = 1'b0;
         end else if (!awaiting_final) begin
            if (ev.frame_type == TYPE_POLL && ev.frame_source == ev.peer_id &&
                ev.frame_dest == node_id) begin
               peer = ev.frame_source;
               poll_stamp = ev.rx_time;
               awaiting_final = 1'b1;
               due = poll_stamp + reply_delay;
               want.outcome = OUT_RESPOND;
               want.response_time = due[TIME_W-1:8];
               want.response_target = peer;
            end
         end else begin
            awaiting_final = 1'b0;
            if (ev.frame_type == TYPE_FINAL && ev.frame_source == peer &&
                ev.frame_dest == node_id) begin
               // Only the low 32 bits of each timestamp difference matter.
               rb = ev.rx_time[31:0] - ev.tx_time[31:0];
               db = ev.tx_time[31:0] - poll_stamp[31:0];
               p1 = 64'(ev.round_a) * 64'(rb);
               p2 = 64'(ev.reply_a) * 64'(db);
               den = 34'(ev.round_a) + 34'(rb) + 34'(ev.reply_a) + 34'(db);
               if (den != '0) begin
                  want.outcome = OUT_DISTANCE;
                  if (p1 > p2) begin
                     flight = (p1 - p2) / 64'(den);
                     if (flight[63:40] != '0) begin
                        want.distance = DIST_MAX;
                     end else begin
                        scaled = flight * 64'(scale);
                        want.distance = (scaled[63:32] != '0) ? DIST_MAX : scaled[31:16];
                     end
                  end
               end
            end
         end
         owed_words.push_back(want);
      endfunction

      function void check_word(rsp_item_type got);
         rsp_item_type want;
         if (owed_words.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("response word with nothing outstanding: outcome %0d time %h target %h dist %0d",
                        got.outcome, got.response_time, got.response_target, got.distance);
            return;
         end
         want = owed_words.pop_front();
         if (got.outcome !== want.outcome || got.response_time !== want.response_time ||
             got.response_target !== want.response_target || got.distance !== want.distance) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected outcome %0d time %h target %h dist %0d, got outcome %0d time %h target %h dist %0d",
                        want.outcome, want.response_time, want.response_target, want.distance,
                        got.outcome, got.response_time, got.response_target, got.distance);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   bit   calm;
   int   hold_request;
   logic [ID_W-1:0] node_id_cur;
   ranging_tracker tracker;

   dstwr_req_if req_bus();
   dstwr_rsp_if rsp_bus();
   dstwr_csr_if csr_bus();

   ds_twr_responder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ds_twr_responder_tb: FAIL");
         $finish;
      end
   end

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic logic [TIME_W-1:0] rand40();
      return {8'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [LEN_W-1:0] valid_length();
      return LEN_W'($urandom_range(0, 24));
   endfunction

   function automatic req_item_type make_frame(logic [TYPE_W-1:0] ftype, logic [ID_W-1:0] src,
                                               logic [ID_W-1:0] dst, logic [LEN_W-1:0] len,
                                               logic [TIME_W-1:0] rxt, logic [TIME_W-1:0] txt,
                                               logic [STAMP_W-1:0] ra, logic [STAMP_W-1:0] da);
      req_item_type ev;
      ev.operation = 1'b0;
      ev.peer_id = src;
      ev.frame_type = ftype;
      ev.frame_source = src;
      ev.frame_dest = dst;
      ev.frame_length = len;
      ev.rx_time = rxt;
      ev.tx_time = txt;
      ev.round_a = ra;
      ev.reply_a = da;
      return ev;
   endfunction

   // Builds a final frame whose wrapped differences come out as rb and db;
   // the upper timestamp bits are random since they drop out.
   function automatic req_item_type make_final(logic [TIME_W-1:0] pt, logic [ID_W-1:0] peer,
                                               logic [31:0] ra, logic [31:0] rb,
                                               logic [31:0] da, logic [31:0] db);
      logic [TIME_W-1:0] txt;
      logic [TIME_W-1:0] rxt;
      req_item_type      ev;
      txt = pt + {8'($urandom), db};
      rxt = txt + {8'($urandom), rb};
      ev = make_frame(TYPE_FINAL, peer, node_id_cur, valid_length(), rxt, txt, ra, da);
      ev.peer_id = 8'($urandom);
      return ev;
   endfunction

   function automatic req_item_type random_noise();
      req_item_type ev;
      ev = make_frame(8'($urandom), 8'($urandom), 8'($urandom), LEN_W'($urandom), rand40(),
                      rand40(), $urandom, $urandom);
      ev.peer_id = 8'($urandom);
      if ($urandom_range(0, 2) == 0) begin
         // Near miss: a poll or final type addressed to this node, with the peer id taken from the source.
         ev.frame_type = $urandom_range(0, 1) ? TYPE_POLL : TYPE_FINAL;
         ev.frame_dest = node_id_cur;
         ev.peer_id = ev.frame_source;
      end
      if ($urandom_range(0, 1) == 0)
         ev.frame_length = valid_length();
      ev.operation = ($urandom_range(0, 7) == 0);
      return ev;
   endfunction

   function automatic req_item_type random_final(logic [TIME_W-1:0] pt, logic [ID_W-1:0] peer);
      logic [31:0]  ra;
      logic [31:0]  rb;
      logic [31:0]  da;
      logic [31:0]  db;
      int           flight;
      req_item_type ev;
      if ($urandom_range(0, 3) == 0) begin
         ra = $urandom;
         rb = $urandom;
         da = $urandom;
         db = $urandom;
      end else begin
         // Consistent round and reply times around a true flight time.
         flight = $urandom_range(0, 4000);
         db = $urandom_range(1, 1 << 22);
         da = $urandom_range(1, 1 << 22);
         ra = db + 32'(2 * flight) + $urandom_range(0, 3);
         rb = da + 32'(2 * flight) + $urandom_range(0, 3);
      end
      ev = make_final(pt, peer, ra, rb, da, db);
      case ($urandom_range(0, 15))
         0: ev.frame_source ^= 8'(1 << $urandom_range(0, 7));
         1: ev.frame_dest ^= 8'(1 << $urandom_range(0, 7));
         2: ev.frame_type ^= 8'(1 << $urandom_range(0, 7));
         3: ev.frame_length = LEN_W'($urandom_range(25, 1023));
         default: ;
      endcase
      return ev;
   endfunction

   // Called at a rising edge; returns at the edge where the word was taken.
   task automatic send_event(req_item_type ev);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= ev.operation;
      req_bus.peer_id <= ev.peer_id;
      req_bus.frame_type <= ev.frame_type;
      req_bus.frame_source <= ev.frame_source;
      req_bus.frame_dest <= ev.frame_dest;
      req_bus.frame_length <= ev.frame_length;
      req_bus.rx_time <= ev.rx_time;
      req_bus.tx_time <= ev.tx_time;
      req_bus.round_a <= ev.round_a;
      req_bus.reply_a <= ev.reply_a;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_event(ev);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.set_register(index, data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(logic [ID_W-1:0] id, logic [TIME_W-1:0] delay,
                                 logic [SCALE_W-1:0] scale);
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(CSR_MY_ID, CSR_DATA_W'(id));
      write_register(CSR_RESPONSE_DELAY, CSR_DATA_W'(delay));
      write_register(CSR_DISTANCE_SCALE, CSR_DATA_W'(scale));
      node_id_cur = id;
   endtask

   task automatic run_directed();
      logic [ID_W-1:0] me;
      req_item_type    ev;
      me = node_id_cur;
      // Poll at the top of the timestamp range, so the response time wraps.
      send_event(make_frame(TYPE_POLL, 8'h3C, me, 10'd24, '1, rand40(), $urandom, $urandom));
      send_event(make_final('1, 8'h3C, 32'd1200, 32'd1400, 32'd1200, 32'd1000));
      ev = make_frame(TYPE_POLL, 8'h3C, me, 10'd10, rand40(), rand40(), '1, '1);
      ev.operation = 1'b1;
      send_event(ev);
      send_event(make_frame(TYPE_POLL, 8'h3C, me, 10'd25, rand40(), '0, '0, '0));
      send_event(make_frame(TYPE_FINAL, 8'h3C, me, 10'd24, rand40(), rand40(), '0, '0));
      ev = make_frame(TYPE_POLL, 8'h3C, me, 10'd24, rand40(), rand40(), '0, '0);
      ev.peer_id = 8'h3D;
      send_event(ev);
      send_event(make_frame(TYPE_POLL, 8'h3C, ~me, 10'd24, rand40(), rand40(), '0, '0));
      // A poll while the final is awaited aborts the exchange.
      send_event(make_frame(TYPE_POLL, 8'h00, me, 10'd0, '0, '0, '0, '0));
      send_event(make_frame(TYPE_POLL, 8'h00, me, 10'd0, '0, '0, '0, '0));
      send_event(make_final('0, 8'h00, 32'd5, 32'd5, 32'd5, 32'd5));
      send_event(make_frame(TYPE_POLL, 8'hFF, me, 10'd1, 40'h12_3456_789A, '0, '0, '0));
      ev = make_final(40'h12_3456_789A, 8'hFF, 32'd500, 32'd500, 32'd400, 32'd400);
      ev.operation = 1'b1;
      send_event(ev);
      send_event(make_final(40'h12_3456_789A, 8'hFF, 32'd500, 32'd500, 32'd400, 32'd400));
      send_event(make_frame(TYPE_POLL, 8'h81, me, 10'd24, 40'h00_FFFF_FFF0, '0, '0, '0));
      ev = make_final(40'h00_FFFF_FFF0, 8'h81, 32'd900, 32'd900, 32'd100, 32'd100);
      ev.frame_length = 10'd1023;
      send_event(ev);
      send_event(make_frame(TYPE_POLL, 8'h81, me, 10'd24, 40'h55_0000_0000, '0, '0, '0));
      ev = make_final(40'h55_0000_0000, 8'h81, 32'd900, 32'd900, 32'd100, 32'd100);
      ev.frame_source = 8'h80;
      send_event(ev);
      // Zero divisor: every round and reply time is zero.
      send_event(make_frame(TYPE_POLL, 8'h42, me, 10'd24, rand40(), '0, '0, '0));
      send_event(make_final(tracker.poll_stamp, 8'h42, '0, '0, '0, '0));
      // Negative flight time.
      send_event(make_frame(TYPE_POLL, 8'h42, me, 10'd24, rand40(), '0, '0, '0));
      send_event(make_final(tracker.poll_stamp, 8'h42, 32'd1, 32'd1, 32'h8000_0000,
                            32'h8000_0000));
      // Very large flight time saturates the distance; equal products give zero.
      send_event(make_frame(TYPE_POLL, 8'h42, me, 10'd24, rand40(), '0, '0, '0));
      send_event(make_final(tracker.poll_stamp, 8'h42, '1, '1, '0, '0));
      send_event(make_frame(TYPE_POLL, 8'h42, me, 10'd24, rand40(), '0, '0, '0));
      send_event(make_final(tracker.poll_stamp, 8'h42, '1, '1, '1, '1));
   endtask

   task automatic run_random_phase(int count);
      int                sent;
      int                pick;
      logic [TIME_W-1:0] pt;
      logic [ID_W-1:0]   peer;
      req_item_type      ev;
      sent = 0;
      while (sent < count) begin
         if (tracker.awaiting_final) begin
            // Clear a leftover exchange with a receive error.
            ev = random_noise();
            ev.operation = 1'b1;
            send_event(ev);
            sent++;
         end
         pick = $urandom_range(0, 9);
         if (pick <= 7) begin
            pt = rand40();
            peer = 8'($urandom);
            send_event(make_frame(TYPE_POLL, peer, node_id_cur, valid_length(), pt, rand40(),
                                  $urandom, $urandom));
            if (pick <= 5)
               send_event(random_final(pt, peer));
            else
               send_event(random_noise());
            sent += 2;
         end else begin
            send_event(random_noise());
            sent++;
         end
      end
   endtask

   initial begin : response_side
      int           gap;
      int           hold;
      rsp_item_type got;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = hold_request;
         hold_request = 0;
         gap = (hold > 0) ? hold : draw_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.outcome = outcome_type'(rsp_bus.outcome);
         got.response_time = rsp_bus.response_time;
         got.response_target = rsp_bus.response_target;
         got.distance = rsp_bus.distance;
         tracker.check_word(got);
      end
   end

   initial begin : request_side
      int phase;
      tracker = new();
      cycle_count = 0;
      calm = 1'b0;
      hold_request = 0;
      node_id_cur = '0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.operation <= 1'b0;
      req_bus.peer_id <= '0;
      req_bus.frame_type <= '0;
      req_bus.frame_source <= '0;
      req_bus.frame_dest <= '0;
      req_bus.frame_length <= '0;
      req_bus.rx_time <= '0;
      req_bus.tx_time <= '0;
      req_bus.round_a <= '0;
      req_bus.reply_a <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_settings(8'hA5, '1, SCALE_RESET);
      run_directed();

      for (phase = 1; phase <= 7; phase++) begin
         calm = 1'b0;
         case (phase)
            1: apply_settings('0, '0, '0);
            2: apply_settings('1, '1, '1);
            3: apply_settings(8'($urandom), rand40(), SCALE_RESET);
            default: apply_settings(8'($urandom), rand40(), SCALE_W'($urandom_range(1, 1 << 20)));
         endcase
         if (phase == 3)
            calm = 1'b1;
         // Stall the response side long enough for the block to back up.
         if (phase == 4)
            hold_request = HOLD_CYCLES;
         run_random_phase(PHASE_ITEMS);
      end

      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.failures == 0)
         $display("ds_twr_responder_tb: PASS");
      else
         $display("ds_twr_responder_tb: FAIL");
      $finish;
   end

endmodule
